// ===== hw/rtl/wwr_pkg.sv =====
`default_nettype none

package wwr_pkg;

    localparam int DEF_MAX_WINDOW  = 4096;
    localparam int DEF_SAMPLE_BITS = 32;

    localparam int CFG_W  = 13;   // window_length register width
    localparam int OUT_W  = 32;   // widest_range width
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = REG_IDX_W'(0);
    localparam logic [CFG_W-1:0]     WINDOW_LENGTH_RST = CFG_W'(1);

    localparam logic Q_MAX = 1'b0;
    localparam logic Q_MIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK_RD,
        ST_BACK_EV,
        ST_FRONT_RD,
        ST_FRONT_EV,
        ST_PUSH,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;       // capture request
        logic sel;        // queue under work
        logic rd_back;
        logic rd_front;
        logic pop_back;
        logic pop_front;
        logic keep_head;  // front entry read back is the queue head
        logic push;
        logic update;     // advance position, fold spread into best
        logic emit;       // load result register, clear set state
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic drop;       // back entry dominated by the new sample
        logic aged;       // front entry outside the window
        logic last;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/wwr_ram.sv =====
`default_nettype none

module wwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/wwr_datapath.sv =====
`default_nettype none

module wwr_datapath #(
    parameter int MAX_WINDOW  = wwr_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = wwr_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire wwr_pkg::t_cmd                           i_cmd,
    output wwr_pkg::t_status                             o_status,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0]         i_k,
    input  wire logic signed [SAMPLE_BITS-1:0]           i_sample,
    input  wire logic                                    i_last,
    output logic                                         o_valid,
    input  wire logic                                    i_stall,
    output logic      [wwr_pkg::OUT_W-1:0]               o_widest_range
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int PW = $clog2(MAX_WINDOW + 1);
    localparam int EW = PW + SAMPLE_BITS;
    localparam int DW = SAMPLE_BITS + 1;
    localparam int OW = wwr_pkg::OUT_W;
    localparam logic [AW-1:0] SLOT_LAST = AW'(MAX_WINDOW - 1);
    localparam logic [PW-1:0] SEEN_MAX  = PW'(MAX_WINDOW);
    localparam logic [63:0]   OUT_MAX   = 64'({OW{1'b1}});

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_last;
    logic [PW-1:0]                 r_pos;
    logic [PW-1:0]                 r_seen;
    logic [OW-1:0]                 r_best;
    logic [AW-1:0]                 r_head [2];
    logic [AW-1:0]                 r_tail [2];
    logic [PW-1:0]                 r_cnt [2];
    logic signed [SAMPLE_BITS-1:0] r_head_val [2];
    logic                          r_out_valid;
    logic [OW-1:0]                 r_out_data;

    logic [AW-1:0]                 cur_head;
    logic [AW-1:0]                 cur_tail;
    logic [PW-1:0]                 cur_cnt;
    logic [AW-1:0]                 back_slot;
    logic [AW-1:0]                 raddr;
    logic [EW-1:0]                 rdata_max;
    logic [EW-1:0]                 rdata_min;
    logic [EW-1:0]                 rdata;
    logic [PW-1:0]                 ent_idx;
    logic signed [SAMPLE_BITS-1:0] ent_val;
    logic [PW-1:0]                 age;
    logic                          we_max;
    logic                          we_min;
    logic [EW-1:0]                 wdata;
    logic [PW-1:0]                 n_seen;
    logic [DW-1:0]                 diff;
    logic [63:0]                   diff64;
    logic [OW-1:0]                 spread;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
        return (p == SLOT_LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] p);
        return (p == '0) ? SLOT_LAST : p - AW'(1);
    endfunction

    assign cur_head  = r_head[i_cmd.sel];
    assign cur_tail  = r_tail[i_cmd.sel];
    assign cur_cnt   = r_cnt[i_cmd.sel];
    assign back_slot = slot_dec(cur_tail);
    assign raddr     = i_cmd.rd_back ? back_slot : cur_head;

    assign wdata  = {r_pos, r_sample};
    assign we_max = i_cmd.push && (i_cmd.sel == wwr_pkg::Q_MAX);
    assign we_min = i_cmd.push && (i_cmd.sel == wwr_pkg::Q_MIN);

    wwr_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WINDOW)
    ) u_max_queue (
        .i_clk   (i_clk),
        .i_we    (we_max),
        .i_waddr (cur_tail),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_max)
    );

    wwr_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WINDOW)
    ) u_min_queue (
        .i_clk   (i_clk),
        .i_we    (we_min),
        .i_waddr (cur_tail),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_min)
    );

    assign rdata   = (i_cmd.sel == wwr_pkg::Q_MIN) ? rdata_min : rdata_max;
    assign ent_idx = rdata[EW-1:SAMPLE_BITS];
    assign ent_val = $signed(rdata[SAMPLE_BITS-1:0]);
    // positions wrap; true age never exceeds MAX_WINDOW
    assign age     = r_pos - ent_idx;

    always_comb begin
        o_status.empty    = (cur_cnt == '0);
        o_status.drop     = (i_cmd.sel == wwr_pkg::Q_MIN) ? (ent_val >= r_sample)
                                                          : (ent_val <= r_sample);
        o_status.aged     = (age >= i_k);
        o_status.last     = r_last;
        o_status.out_busy = r_out_valid && i_stall;
    end

    // head max minus head min is never negative
    assign n_seen = (r_seen == SEEN_MAX) ? r_seen : r_seen + PW'(1);
    assign diff   = {r_head_val[0][SAMPLE_BITS-1], r_head_val[0]}
                  - {r_head_val[1][SAMPLE_BITS-1], r_head_val[1]};
    assign diff64 = 64'(diff);
    assign spread = (diff64 > OUT_MAX) ? {OW{1'b1}} : diff64[OW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_pos     <= '0;
            r_seen    <= '0;
            r_best    <= '0;
            r_head[0] <= '0;
            r_head[1] <= '0;
            r_tail[0] <= '0;
            r_tail[1] <= '0;
            r_cnt[0]  <= '0;
            r_cnt[1]  <= '0;
        end else begin
            if (i_cmd.pop_back) begin
                r_tail[i_cmd.sel] <= back_slot;
                r_cnt[i_cmd.sel]  <= cur_cnt - PW'(1);
            end
            if (i_cmd.pop_front) begin
                r_head[i_cmd.sel] <= slot_inc(cur_head);
                r_cnt[i_cmd.sel]  <= cur_cnt - PW'(1);
            end
            if (i_cmd.push) begin
                r_tail[i_cmd.sel] <= slot_inc(cur_tail);
                r_cnt[i_cmd.sel]  <= cur_cnt + PW'(1);
            end
            if (i_cmd.update) begin
                r_pos  <= r_pos + PW'(1);
                r_seen <= n_seen;
                if ((n_seen >= i_k) && (spread > r_best)) begin
                    r_best <= spread;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_last   <= i_last;
        end
        if (i_cmd.keep_head) begin
            r_head_val[i_cmd.sel] <= ent_val;
        end else if (i_cmd.push && (cur_cnt == '0)) begin
            r_head_val[i_cmd.sel] <= r_sample;
        end
        if (i_cmd.emit) begin
            r_out_data <= r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_widest_range = r_out_data;

    a_emit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !(r_out_valid && i_stall))
        else $error("result overwritten while stalled");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= SEEN_MAX) && (r_cnt[1] <= SEEN_MAX))
        else $error("queue count beyond depth");

    a_update_heads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> (r_cnt[0] != '0) && (r_cnt[1] != '0)
                         && (r_head_val[0] >= r_head_val[1]))
        else $error("queue heads inconsistent at update");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_cnt[0] == '0) && (r_cnt[1] == '0) && (r_best == '0) && r_out_valid)
        else $error("set state not cleared after emit");

endmodule

`default_nettype wire

// ===== hw/rtl/wwr_ctrl.sv =====
`default_nettype none

module wwr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire wwr_pkg::t_status i_status,
    output wwr_pkg::t_cmd         o_cmd
);

    wwr_pkg::t_state r_state;
    wwr_pkg::t_state n_state;
    logic            r_sel;
    logic            n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wwr_pkg::ST_IDLE;
            r_sel   <= wwr_pkg::Q_MAX;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        o_cmd     = '0;
        o_cmd.sel = r_sel;
        unique case (r_state)
            wwr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_sel      = wwr_pkg::Q_MAX;
                    n_state    = wwr_pkg::ST_BACK_RD;
                end
            end
            wwr_pkg::ST_BACK_RD: begin
                if (i_status.empty) begin
                    n_state = wwr_pkg::ST_PUSH;
                end else begin
                    o_cmd.rd_back = 1'b1;
                    n_state       = wwr_pkg::ST_BACK_EV;
                end
            end
            wwr_pkg::ST_BACK_EV: begin
                if (i_status.drop) begin
                    o_cmd.pop_back = 1'b1;
                    n_state        = wwr_pkg::ST_BACK_RD;
                end else begin
                    n_state = wwr_pkg::ST_FRONT_RD;
                end
            end
            wwr_pkg::ST_FRONT_RD: begin
                if (i_status.empty) begin
                    n_state = wwr_pkg::ST_PUSH;
                end else begin
                    o_cmd.rd_front = 1'b1;
                    n_state        = wwr_pkg::ST_FRONT_EV;
                end
            end
            wwr_pkg::ST_FRONT_EV: begin
                if (i_status.aged) begin
                    o_cmd.pop_front = 1'b1;
                    n_state         = wwr_pkg::ST_FRONT_RD;
                end else begin
                    o_cmd.keep_head = 1'b1;
                    n_state         = wwr_pkg::ST_PUSH;
                end
            end
            wwr_pkg::ST_PUSH: begin
                o_cmd.push = 1'b1;
                if (r_sel == wwr_pkg::Q_MAX) begin
                    n_sel   = wwr_pkg::Q_MIN;
                    n_state = wwr_pkg::ST_BACK_RD;
                end else begin
                    n_state = wwr_pkg::ST_UPDATE;
                end
            end
            wwr_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.last ? wwr_pkg::ST_EMIT : wwr_pkg::ST_IDLE;
            end
            wwr_pkg::ST_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = wwr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wwr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != wwr_pkg::ST_IDLE);

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == wwr_pkg::ST_BACK_RD) && (r_sel == wwr_pkg::Q_MAX))
        else $error("request started out of order");

    a_update_after_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |-> $past(o_cmd.push) && (r_sel == wwr_pkg::Q_MIN))
        else $error("update before both queues pushed");

endmodule

`default_nettype wire

// ===== hw/rtl/widest_window_range_unit.sv =====
`default_nettype none

// Widest window range: largest (max - min) over all full windows of a set.
//
// Input channel (i_valid / o_stall) carries one signed sample per request,
// i_last marking the end of the set. Output channel (o_valid / i_stall)
// carries one widest_range result per set, 0 when the set is shorter than
// the window. window_length is written over the APB port (address 0); the
// user must write it only while the block is idle, which the block itself
// does not enforce. 0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW.
//
// Each sample goes through the max queue, then the min queue, at most one
// RAM access per sequencer step: back read and evaluate, repeated while the
// back entry is popped, then front read and evaluate, repeated while the
// front entry is popped, then push. An empty queue skips to the push. After
// the last sample's update step, the emit step loads the result register,
// waiting while an earlier result is still held by i_stall.
//
// The result register holds while i_stall is high; the next set's samples
// are still taken, and only a second result waits for the first to leave.
// Reset (synchronous) empties both queues, clears the running best and sets
// window_length to 1; no memory clearing pass is needed.
module widest_window_range_unit #(
    parameter int MAX_WINDOW  = wwr_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = wwr_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  wire logic                              i_last,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [wwr_pkg::OUT_W-1:0]         o_widest_range,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [wwr_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [wwr_pkg::DATA_W-1:0]        pwdata,
    output logic      [wwr_pkg::DATA_W-1:0]        prdata,
    output logic                                   pready
);

    localparam int PW = $clog2(MAX_WINDOW + 1);

    logic [wwr_pkg::CFG_W-1:0]     r_window_length;
    logic [wwr_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_wr;
    logic [31:0]                   wl32;
    logic [PW-1:0]                 k_eff;
    wwr_pkg::t_cmd                 cmd;
    wwr_pkg::t_status              status;

    assign reg_idx = paddr[wwr_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= wwr_pkg::WINDOW_LENGTH_RST;
        end else if (cfg_wr && (reg_idx == wwr_pkg::REG_WINDOW_LENGTH)) begin
            r_window_length <= pwdata[wwr_pkg::CFG_W-1:0];
        end
    end

    assign prdata = (reg_idx == wwr_pkg::REG_WINDOW_LENGTH)
                  ? wwr_pkg::DATA_W'(r_window_length) : '0;

    assign wl32  = 32'(r_window_length);
    assign k_eff = (wl32 == 32'd0)              ? PW'(1)
                 : (wl32 > 32'(MAX_WINDOW))     ? PW'(MAX_WINDOW)
                 : PW'(wl32);

    wwr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    wwr_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_k            (k_eff),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_widest_range (o_widest_range)
    );

endmodule

`default_nettype wire

// ===== dv/widest_range_checker.sv =====
`default_nettype none

module widest_range_checker
    import wwr_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          o_stall,
    input  wire logic signed [DEF_SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_last,
    input  wire logic                          o_valid,
    input  wire logic                          i_stall,
    input  wire logic [OUT_W-1:0]              o_widest_range,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ADDR_W-1:0]             paddr,
    input  wire logic [DATA_W-1:0]             pwdata,
    input  wire logic                          pready,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QDEPTH     = DEF_MAX_WINDOW;
    localparam longint      SPREAD_CAP = 64'h0000_0000_FFFF_FFFF;

    // monotone queues of (value, position); index Q_MAX / Q_MIN
    longint      q_val [2][QDEPTH];
    int unsigned q_pos [2][QDEPTH];
    int unsigned q_head[2];
    int unsigned q_cnt [2];

    int unsigned      set_pos;
    int unsigned      seen;
    logic [OUT_W-1:0] best;
    logic [CFG_W-1:0] window_reg;

    logic [OUT_W-1:0] expected_ranges[$];

    int fails   = 0;
    int checked = 0;

    function automatic void clear_set();
        q_head[Q_MAX] = 0;
        q_head[Q_MIN] = 0;
        q_cnt[Q_MAX]  = 0;
        q_cnt[Q_MIN]  = 0;
        set_pos       = 0;
        seen          = 0;
        best          = '0;
    endfunction

    function automatic void advance_queue(input logic qs, input longint v,
                                          input int unsigned pos, input int unsigned k);
        int unsigned slot;
        bit          done;
        // age out the front, then drop dominated entries from the back
        while (q_cnt[qs] > 0 && (pos - q_pos[qs][q_head[qs]]) >= k) begin
            q_head[qs] = (q_head[qs] + 1) % QDEPTH;
            q_cnt[qs]  = q_cnt[qs] - 1;
        end
        done = 1'b0;
        while (q_cnt[qs] > 0 && !done) begin
            slot = (q_head[qs] + q_cnt[qs] - 1) % QDEPTH;
            if ((qs == Q_MAX) ? (q_val[qs][slot] <= v) : (q_val[qs][slot] >= v))
                q_cnt[qs] = q_cnt[qs] - 1;
            else
                done = 1'b1;
        end
        if (q_cnt[qs] < QDEPTH) begin
            slot = (q_head[qs] + q_cnt[qs]) % QDEPTH;
            q_val[qs][slot] = v;
            q_pos[qs][slot] = pos;
            q_cnt[qs]       = q_cnt[qs] + 1;
        end
    endfunction

    function automatic void take_sample(input logic signed [DEF_SAMPLE_BITS-1:0] s,
                                        input logic lst);
        int unsigned      k;
        longint           v;
        longint           diff;
        logic [OUT_W-1:0] spread;
        v = longint'(s);
        k = window_reg;
        if (k == 0)
            k = 1;
        if (k > QDEPTH)
            k = QDEPTH;
        advance_queue(Q_MAX, v, set_pos, k);
        advance_queue(Q_MIN, v, set_pos, k);
        set_pos = set_pos + 1;
        if (seen != 32'hFFFF_FFFF)
            seen = seen + 1;
        if (seen >= k) begin
            diff   = q_val[Q_MAX][q_head[Q_MAX]] - q_val[Q_MIN][q_head[Q_MIN]];
            spread = (diff > SPREAD_CAP) ? SPREAD_CAP[OUT_W-1:0] : diff[OUT_W-1:0];
            if (spread > best)
                best = spread;
        end
        if (lst) begin
            expected_ranges.push_back(best);
            clear_set();
        end
    endfunction

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            clear_set();
            window_reg = WINDOW_LENGTH_RST;
            expected_ranges.delete();
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_ranges.size() == 0) begin
                    $error("widest_range: no set pending, got %0d", o_widest_range);
                    fails++;
                end else begin
                    want = expected_ranges.pop_front();
                    checked++;
                    if (o_widest_range !== want) begin
                        $error("widest_range: expected %0d, actual %0d", want, o_widest_range);
                        fails++;
                    end
                end
            end
            if (psel && penable && pwrite && pready
                    && paddr[ADDR_W-1:2] == REG_WINDOW_LENGTH)
                window_reg = pwdata[CFG_W-1:0];
            if (i_valid && !o_stall)
                take_sample(i_sample, i_last);
        end
        o_fail_count <= fails;
        o_pending    <= expected_ranges.size();
        o_checked    <= checked;
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
    import wwr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW             = DEF_SAMPLE_BITS;
    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 150;

    localparam logic [ADDR_W-1:0] WINDOW_ADDR   = ADDR_W'({REG_WINDOW_LENGTH, 2'b00});
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4);

    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};

    typedef enum int {
        CONTENT_FULL,
        CONTENT_NARROW,
        CONTENT_RISING,
        CONTENT_FALLING,
        CONTENT_EXTREME
    } content_t;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   i_valid   = 1'b0;
    logic                   o_stall;
    logic signed [SW-1:0]   i_sample  = '0;
    logic                   i_last    = 1'b0;
    logic                   o_valid;
    logic                   i_stall   = 1'b0;
    logic [OUT_W-1:0]       o_widest_range;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [ADDR_W-1:0]      paddr     = '0;
    logic [DATA_W-1:0]      pwdata    = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    int fail_count;
    int pending_ranges;
    int checked_ranges;

    int items_sent     = 0;
    int settings_used  = 0;
    int burst_left     = 0;
    int eff_window     = 1;
    int quiet_cycles   = 0;
    bit long_hold_req  = 1'b0;

    widest_window_range_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_widest_range (o_widest_range),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    widest_range_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_widest_range (o_widest_range),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending_ranges),
        .o_checked      (checked_ranges)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: stall patterns in segments, plus one long hold-off on request
    initial begin
        int          seg_len;
        int          pct;
        stall_mode_t mode;
        forever begin
            seg_len = $urandom_range(10, 300);
            pct     = $urandom_range(10, 90);
            case ($urandom_range(0, 3))
                0: mode = STALL_NONE;
                1: mode = STALL_RANDOM;
                2: mode = STALL_PERIODIC;
                default: mode = STALL_HEAVY;
            endcase
            for (int n = 0; n < seg_len && !long_hold_req; n++) begin
                case (mode)
                    STALL_NONE:     i_stall <= 1'b0;
                    STALL_RANDOM:   i_stall <= ($urandom_range(0, 99) < pct);
                    STALL_PERIODIC: i_stall <= ((n % 4) == 3);
                    default:        i_stall <= ((n % 16) < 11);
                endcase
                @(posedge i_clk);
            end
            if (long_hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sender in bursts; valid stays high within a burst
    task automatic push_sample(input logic signed [SW-1:0] s, input logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        i_last   <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_set(input int len, input content_t style);
        logic signed [SW-1:0] s;
        s = $urandom;
        for (int i = 0; i < len; i++) begin
            case (style)
                CONTENT_FULL:    s = $urandom;
                CONTENT_NARROW:  begin
                    s = $urandom_range(0, 8);
                    s = s - 4;
                end
                CONTENT_RISING:  s = s + $urandom_range(0, 3);
                CONTENT_FALLING: s = s - $urandom_range(0, 3);
                default: begin
                    case ($urandom_range(0, 3))
                        0: s = SAMPLE_MIN;
                        1: s = SAMPLE_MAX;
                        2: s = 0;
                        default: s = -1;
                    endcase
                end
            endcase
            push_sample(s, i == len - 1);
        end
    endtask

    // drain every pending range, give the block time to go idle, then reprogram
    task automatic set_window(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        i_valid    <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_ranges != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(addr, data);
        if (addr == WINDOW_ADDR) begin
            eff_window = data[CFG_W-1:0];
            if (eff_window == 0)
                eff_window = 1;
            if (eff_window > DEF_MAX_WINDOW)
                eff_window = DEF_MAX_WINDOW;
        end
        settings_used++;
    endtask

    task automatic random_phase(input int items);
        int       len;
        int       r;
        int       done_items;
        content_t style;
        done_items = 0;
        while (done_items < items) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                len = $urandom_range(eff_window, 3 * eff_window + 2);
            else if (r < 9 && eff_window > 1)
                len = $urandom_range(1, eff_window - 1);
            else
                len = $urandom_range(1, 4);
            r = $urandom_range(0, 9);
            if (r < 5)
                style = CONTENT_FULL;
            else if (r < 7)
                style = CONTENT_NARROW;
            else if (r == 7)
                style = CONTENT_RISING;
            else if (r == 8)
                style = CONTENT_FALLING;
            else
                style = CONTENT_EXTREME;
            send_set(len, style);
            done_items += len;
        end
    endtask

    initial begin
        int unsigned phase_windows[9];
        int unsigned wl;
        phase_windows = '{1, 2, 3, 4, 5, 8, 13, 31, 64};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window of one: every spread is zero
        settings_used++;
        push_sample(5, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);

        set_window(WINDOW_ADDR, 2);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b1);
        push_sample(7, 1'b1);               // set shorter than the window
        push_sample(3, 1'b0);               // ties in both queues
        push_sample(3, 1'b0);
        push_sample(3, 1'b1);
        push_sample(-1, 1'b0);
        push_sample(0, 1'b0);
        push_sample(1, 1'b0);
        push_sample(-2, 1'b1);

        set_window(WINDOW_ADDR, 0);         // zero acts as one
        push_sample(1, 1'b0);
        push_sample(100, 1'b1);

        set_window(UNMAPPED_ADDR, 9);       // no register there
        push_sample(4, 1'b0);
        push_sample(-4, 1'b1);

        set_window(WINDOW_ADDR, 13'h1FFF);  // saturates to the deepest window
        send_set(3, CONTENT_FULL);

        set_window(WINDOW_ADDR, DEF_MAX_WINDOW + 1);
        send_set(5, CONTENT_EXTREME);

        set_window(WINDOW_ADDR, DEF_MAX_WINDOW);
        send_set(6, CONTENT_RISING);

        for (int p = 0; p < 11; p++) begin
            wl = (p < 9) ? phase_windows[p] : $urandom_range(1, 48);
            if (p == 2) begin
                // upper data bits must be ignored
                set_window(WINDOW_ADDR, 32'hA5A5_0000 | wl);
                long_hold_req = 1'b1;
                for (int n = 0; n < 8; n++)
                    send_set($urandom_range(2, 6), CONTENT_FULL);
            end else begin
                set_window(WINDOW_ADDR, wl);
            end
            random_phase(PHASE_ITEMS);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_ranges != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d samples over %0d window settings (zero, 1..64, 4096, saturated)",
                 items_sent, settings_used);
        $display("summary: %0d ranges checked, incl. a long receiver hold-off that blocked input",
                 checked_ranges);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/wwr_pkg.sv
hw/rtl/wwr_ram.sv
hw/rtl/wwr_datapath.sv
hw/rtl/wwr_ctrl.sv
hw/rtl/widest_window_range_unit.sv
dv/widest_range_checker.sv
dv/testbench.sv
